// ----- src/source_text_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// source text tokenizer assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// consequent checked in the same cycle
`define STT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// token kinds, error codes, result record and queue types shared by the
// tokenizer modules
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [4:0] K_EOF       = 5'd0;
    localparam logic [4:0] K_IDENT     = 5'd1;
    localparam logic [4:0] K_INTEGER   = 5'd2;
    localparam logic [4:0] K_STRING    = 5'd3;
    localparam logic [4:0] K_EQUAL     = 5'd4;
    localparam logic [4:0] K_HASH      = 5'd5;
    localparam logic [4:0] K_PLUS      = 5'd6;
    localparam logic [4:0] K_MINUS     = 5'd7;
    localparam logic [4:0] K_STAR      = 5'd8;
    localparam logic [4:0] K_SLASH     = 5'd9;
    localparam logic [4:0] K_COMMA     = 5'd10;
    localparam logic [4:0] K_PERIOD    = 5'd11;
    localparam logic [4:0] K_SEMICOLON = 5'd12;
    localparam logic [4:0] K_RPAREN    = 5'd13;
    localparam logic [4:0] K_LPAREN    = 5'd14;
    localparam logic [4:0] K_ASSIGN    = 5'd15;
    localparam logic [4:0] K_COLON     = 5'd16;
    localparam logic [4:0] K_LESS_EQ   = 5'd17;
    localparam logic [4:0] K_LESS      = 5'd18;
    localparam logic [4:0] K_GREATER_EQ = 5'd19;
    localparam logic [4:0] K_GREATER   = 5'd20;
    localparam logic [4:0] K_UNKNOWN   = 5'd21;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_HEX     = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;
    localparam logic [1:0] ERR_COMMENT = 2'd3;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  err;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic                 room;
        logic [QCNT_BITS-1:0] level;
    } t_q_status;

endpackage

// ----- src/stt_if.sv -----
// ----------------------------------------------------------------------------
// stt_if
// valid/ready channels for text bytes in and tokens out
// ----------------------------------------------------------------------------
interface stt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_in_run;

    modport source (output valid, output token_kind, output error_code,
                    output token_start, output token_length, output last_in_run,
                    input ready);
    modport sink   (input valid, input token_kind, input error_code,
                    input token_start, input token_length, input last_in_run,
                    output ready);
endinterface

// ----- src/stt_front.sv -----
// ----------------------------------------------------------------------------
// stt_front
// scanner state machine: takes one text byte per cycle while the result queue
// has room, and pushes up to two finished tokens per transaction into the queue
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
    parameter int POS_BITS  = 16,
    parameter int MAX_DEPTH = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_text_if.sink   i_text,
    input  t_q_status  i_q_status,
    output t_push      o_push
);

    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [3:0] {
        S_IDLE, S_IDENT, S_NUMBER, S_STRING, S_LPAREN, S_PAIR,
        S_COMMENT, S_COMMENT_LP, S_COMMENT_ST
    } t_mode;

    typedef enum logic [1:0] {P_NONE, P_COLON, P_LESS, P_GREATER} t_pair;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return c >= "A" && c <= "F";
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_FF || c == CH_VT ||
               c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [4:0] pair_kind(input t_pair p, input logic with_eq);
        logic [4:0] k;
        unique case (p)
            P_COLON: k = with_eq ? K_ASSIGN : K_COLON;
            P_LESS:  k = with_eq ? K_LESS_EQ : K_LESS;
            default: k = with_eq ? K_GREATER_EQ : K_GREATER;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "=":     k = K_EQUAL;
            "#":     k = K_HASH;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            ",":     k = K_COMMA;
            ".":     k = K_PERIOD;
            ";":     k = K_SEMICOLON;
            ")":     k = K_RPAREN;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic t_result mk(input logic [4:0] kind, input logic [1:0] err,
                                   input logic [15:0] start, input logic [15:0] len);
        t_result r;
        r.kind  = kind;
        r.err   = err;
        r.start = start;
        r.len   = len;
        r.last  = 1'b0;
        return r;
    endfunction

    t_mode                 r_mode,  n_mode;
    logic [POS_BITS-1:0]   r_pos,   n_pos;
    logic [POS_BITS-1:0]   r_start, n_start;
    logic [15:0]           r_len,   n_len;
    logic                  r_hex,   n_hex;
    logic                  r_quote, n_quote;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    t_pair                 r_pair,  n_pair;

    logic                  accept;
    logic [7:0]            c;
    logic [15:0]           start16;
    logic [15:0]           pos16;
    logic [15:0]           len_inc;
    logic [DEPTH_BITS-1:0] depth_dec;
    logic                  again;
    logic                  a_vld, b_vld;
    t_result               a_res, b_res;

    assign i_text.ready = i_q_status.room;
    assign accept       = i_text.valid && i_text.ready;
    assign c            = i_text.text_byte;
    assign start16      = 16'(r_start);
    assign pos16        = 16'(r_pos);
    assign len_inc      = (r_len == LEN_MAX) ? r_len : r_len + 16'd1;
    assign depth_dec    = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos + 1'b1;
        n_start = r_start;
        n_len   = r_len;
        n_hex   = r_hex;
        n_quote = r_quote;
        n_depth = r_depth;
        n_pair  = r_pair;
        again   = 1'b0;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        a_res   = '0;
        b_res   = '0;

        if (i_text.end_of_text) begin
            unique case (r_mode)
                S_IDENT: begin
                    a_vld = 1'b1;
                    a_res = mk(K_IDENT, ERR_NONE, start16, r_len);
                end
                S_NUMBER: begin
                    a_vld = 1'b1;
                    a_res = mk(K_INTEGER, r_hex ? ERR_HEX : ERR_NONE, start16, r_len);
                end
                S_STRING: begin
                    a_vld = 1'b1;
                    a_res = mk(K_STRING, ERR_STRING, start16, r_len);
                end
                S_LPAREN: begin
                    a_vld = 1'b1;
                    a_res = mk(K_LPAREN, ERR_NONE, start16, 16'd1);
                end
                S_PAIR: begin
                    a_vld = 1'b1;
                    a_res = mk(pair_kind(r_pair, 1'b0), ERR_NONE, start16, 16'd1);
                end
                default: ;
            endcase
            b_vld = 1'b1;
            b_res = mk(K_EOF, ERR_NONE, pos16, 16'd0);
            if ((r_mode == S_COMMENT || r_mode == S_COMMENT_LP ||
                 r_mode == S_COMMENT_ST) && r_depth != '0) begin
                b_res.err = ERR_COMMENT;
            end
            n_mode  = S_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
            n_hex   = 1'b0;
            n_quote = 1'b0;
            n_depth = '0;
            n_pair  = P_NONE;
        end else begin
            unique case (r_mode)
                S_IDENT: begin
                    if (is_head(c) || is_digit(c)) begin
                        n_len = len_inc;
                    end else begin
                        a_vld = 1'b1;
                        a_res = mk(K_IDENT, ERR_NONE, start16, r_len);
                        again = 1'b1;
                    end
                end
                S_NUMBER: begin
                    if (is_digit(c) || is_hex_letter(c)) begin
                        if (!is_digit(c)) begin
                            n_hex = 1'b1;
                        end
                        n_len = len_inc;
                    end else if (c == "H") begin
                        n_len  = len_inc;
                        a_vld  = 1'b1;
                        a_res  = mk(K_INTEGER, ERR_NONE, start16, len_inc);
                        n_mode = S_IDLE;
                    end else begin
                        a_vld = 1'b1;
                        a_res = mk(K_INTEGER, r_hex ? ERR_HEX : ERR_NONE, start16, r_len);
                        again = 1'b1;
                    end
                end
                S_STRING: begin
                    n_len = len_inc;
                    if (c == (r_quote ? 8'h27 : 8'h22)) begin
                        a_vld  = 1'b1;
                        a_res  = mk(K_STRING, ERR_NONE, start16, len_inc);
                        n_mode = S_IDLE;
                    end else if (c == CH_CR || c == CH_LF) begin
                        a_vld  = 1'b1;
                        a_res  = mk(K_STRING, ERR_STRING, start16, len_inc);
                        n_mode = S_IDLE;
                    end
                end
                S_LPAREN: begin
                    if (c == "*") begin
                        n_mode  = S_COMMENT;
                        n_depth = DEPTH_BITS'(1);
                    end else begin
                        a_vld = 1'b1;
                        a_res = mk(K_LPAREN, ERR_NONE, start16, 16'd1);
                        again = 1'b1;
                    end
                end
                S_PAIR: begin
                    n_pair = P_NONE;
                    if (c == "=") begin
                        a_vld  = 1'b1;
                        a_res  = mk(pair_kind(r_pair, 1'b1), ERR_NONE, start16, 16'd2);
                        n_mode = S_IDLE;
                    end else begin
                        a_vld = 1'b1;
                        a_res = mk(pair_kind(r_pair, 1'b0), ERR_NONE, start16, 16'd1);
                        again = 1'b1;
                    end
                end
                S_COMMENT_LP: begin
                    if (c == "*") begin
                        if (r_depth < DEPTH_MAX) begin
                            n_depth = r_depth + 1'b1;
                        end
                        n_mode = S_COMMENT;
                    end else begin
                        n_mode = (c == "(") ? S_COMMENT_LP : S_COMMENT;
                    end
                end
                S_COMMENT_ST: begin
                    if (c == ")") begin
                        n_depth = depth_dec;
                        n_mode  = (depth_dec == '0) ? S_IDLE : S_COMMENT;
                    end else begin
                        n_mode = (c == "(") ? S_COMMENT_LP :
                                 (c == "*") ? S_COMMENT_ST : S_COMMENT;
                    end
                end
                S_COMMENT: begin
                    n_mode = (c == "(") ? S_COMMENT_LP :
                             (c == "*") ? S_COMMENT_ST : S_COMMENT;
                end
                default: again = 1'b1;
            endcase

            // byte that ended a token, or any byte between tokens
            if (again) begin
                n_mode = S_IDLE;
                priority if (is_space(c)) begin
                end else if (is_head(c)) begin
                    n_mode  = S_IDENT;
                    n_start = r_pos;
                    n_len   = 16'd1;
                end else if (is_digit(c)) begin
                    n_mode  = S_NUMBER;
                    n_start = r_pos;
                    n_len   = 16'd1;
                    n_hex   = 1'b0;
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_mode  = S_STRING;
                    n_start = r_pos;
                    n_len   = 16'd1;
                    n_quote = (c == 8'h27);
                end else if (c == "(") begin
                    n_mode  = S_LPAREN;
                    n_start = r_pos;
                    n_len   = 16'd1;
                end else if (c == ":" || c == "<" || c == ">") begin
                    n_mode  = S_PAIR;
                    n_start = r_pos;
                    n_len   = 16'd1;
                    n_pair  = (c == ":") ? P_COLON : (c == "<") ? P_LESS : P_GREATER;
                end else begin
                    b_vld = 1'b1;
                    b_res = mk(op_kind(c), ERR_NONE, pos16, 16'd1);
                end
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (a_vld) begin
            o_push.first  = a_res;
            o_push.second = b_res;
            o_push.count  = b_vld ? 2'd2 : 2'd1;
            if (b_vld) begin
                o_push.second.last = 1'b1;
            end else begin
                o_push.first.last = 1'b1;
            end
        end else begin
            o_push.first      = b_res;
            o_push.first.last = 1'b1;
            o_push.count      = {1'b0, b_vld};
        end
        if (!accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_hex   <= 1'b0;
            r_quote <= 1'b0;
            r_depth <= '0;
            r_pair  <= P_NONE;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_hex   <= n_hex;
            r_quote <= n_quote;
            r_depth <= n_depth;
            r_pair  <= n_pair;
        end
    end

endmodule

// ----- src/stt_queue.sv -----
// ----------------------------------------------------------------------------
// stt_queue
// result queue: takes up to two tokens per cycle from the scanner and hands
// them out one per transaction on the token channel
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output t_q_status   o_status,
    stt_token_if.source o_token
);

    t_result              r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_count, n_count;
    logic                 pop;
    t_result              head;

    assign head                 = r_mem[r_rd];
    assign o_token.valid        = (r_count != '0);
    assign o_token.token_kind   = head.kind;
    assign o_token.error_code   = head.err;
    assign o_token.token_start  = head.start;
    assign o_token.token_length = head.len;
    assign o_token.last_in_run  = head.last;
    assign pop                  = o_token.valid && o_token.ready;

    assign o_status.room  = (r_count <= QCNT_BITS'(QDEPTH - 2));
    assign o_status.level = r_count;

    assign n_wr    = r_wr + QPTR_BITS'(i_push.count);
    assign n_rd    = r_rd + QPTR_BITS'(pop);
    assign n_count = r_count + QCNT_BITS'(i_push.count) - QCNT_BITS'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- src/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming lexical scanner: text bytes in, tokens with kind, error,
// start offset and length out
// ----------------------------------------------------------------------------
// i_text carries one text byte per transaction, or an end marker when
// end_of_text is set. o_token carries one token per transaction; the last
// token caused by an input byte has last_in_run set, and an end marker always
// yields an eof token last.
// throughput: one byte per cycle while the result queue has room for two
// tokens; the queue drains one token per cycle while o_token.ready is high.
// a token is written into the result queue when the byte that ends it is taken
// (a token ends on its own closing byte or on the first byte that is not in it).
// the four-entry queue between scanner and output lets the receiver stall;
// i_text.ready drops once fewer than two entries are free.
// reset (synchronous, active low) returns the scanner to offset zero between
// tokens and empties the queue; an end marker does the same for the scanner.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer import stt_pkg::*; #(
    parameter int POS_BITS  = 16,
    parameter int MAX_DEPTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_text_if.sink    i_text,
    stt_token_if.source o_token
);

    t_push     push;
    t_q_status q_status;

    stt_front #(
        .POS_BITS  (POS_BITS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (i_text),
        .i_q_status (q_status),
        .o_push     (push)
    );

    stt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (q_status),
        .o_token  (o_token)
    );

    `STT_ASSERT_NOW(a_level_bound, 1'b1, q_status.level <= QCNT_BITS'(QDEPTH), "queue overfilled")
    `STT_ASSERT_NOW(a_eof_last, o_token.valid && o_token.token_kind == K_EOF, o_token.last_in_run, "eof token not last in run")
    `STT_ASSERT_NEXT(a_end_queued, i_text.valid && i_text.ready && i_text.end_of_text, q_status.level != '0, "end marker left no token")

endmodule

// ----- tb/source_text_tokenizer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// drives source text into the tokenizer and checks every token against a
// scanner model kept in step with the accepted bytes; a short table of
// hand-checked bytes comes first, then random lexemes, a deep comment nest,
// more random lexemes and a final stretch with no stalls on either side
// ----------------------------------------------------------------------------
module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int          MAX_DEPTH = 255;
    localparam int          LIMIT     = 200_000;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_VT     = 8'h0B;
    localparam logic [7:0]  CH_FF     = 8'h0C;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam t_result     NO_TOK    = '0;

    typedef enum logic [3:0] {
        SM_IDLE, SM_IDENT, SM_NUMBER, SM_STRING, SM_LPAREN, SM_PAIR,
        SM_COMMENT, SM_COMMENT_LP, SM_COMMENT_ST
    } t_lex_mode;

    typedef enum logic [1:0] {
        PAIR_NONE, PAIR_COLON, PAIR_LESS, PAIR_GREATER
    } t_pair;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic [1:0] n_typed;
        t_result    r0;
        t_result    r1;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h41, 1'b1, 2'd1, '{K_EOF, ERR_NONE, 16'd0, 16'd0, 1'b1}, NO_TOK},
        '{"A",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"9",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{" ",   1'b0, 2'd1, '{K_IDENT, ERR_NONE, 16'd0, 16'd2, 1'b1}, NO_TOK},
        '{"1",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"F",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{";",   1'b0, 2'd2, '{K_INTEGER, ERR_HEX, 16'd3, 16'd2, 1'b0},
                             '{K_SEMICOLON, ERR_NONE, 16'd5, 16'd1, 1'b1}},
        '{"7",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"H",   1'b0, 2'd1, '{K_INTEGER, ERR_NONE, 16'd6, 16'd2, 1'b1}, NO_TOK},
        '{"'",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"\"",  1'b0, 2'd0, NO_TOK, NO_TOK},
        '{CH_LF, 1'b0, 2'd1, '{K_STRING, ERR_STRING, 16'd8, 16'd3, 1'b1}, NO_TOK},
        '{"(",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"*",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'hFF, 1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"*",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{")",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{":",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"=",   1'b0, 2'd1, '{K_ASSIGN, ERR_NONE, 16'd16, 16'd2, 1'b1}, NO_TOK},
        '{"<",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h00, 1'b0, 2'd2, '{K_LESS, ERR_NONE, 16'd18, 16'd1, 1'b0},
                             '{K_UNKNOWN, ERR_NONE, 16'd19, 16'd1, 1'b1}},
        '{"(",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{"*",   1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'h00, 1'b1, 2'd1, '{K_EOF, ERR_COMMENT, 16'd22, 16'd0, 1'b1}, NO_TOK},
        '{"\"",  1'b0, 2'd0, NO_TOK, NO_TOK},
        '{8'hFF, 1'b1, 2'd2, '{K_STRING, ERR_STRING, 16'd0, 16'd1, 1'b0},
                             '{K_EOF, ERR_NONE, 16'd1, 16'd0, 1'b1}}
    };

    localparam string HEAD_CHARS  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_CHARS  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string DIGITS      = "0123456789";
    localparam string HEX_DIGITS  = "0123456789ABCDEF";
    localparam string OP_CHARS    = "=#+-*/,.;)(";
    localparam string ODD_CHARS   = "!$%&?@[\\]^{|}~";
    localparam string NEST_CHARS  = "()*a ";

    logic i_clk = 1'b0;
    logic i_rst_n;

    stt_text_if  text_ch ();
    stt_token_if token_ch ();

    source_text_tokenizer #(
        .POS_BITS  (16),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_token (token_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scanner model state
    t_lex_mode   lex_mode;
    t_pair       lex_pair;
    logic [15:0] lex_pos;
    logic [15:0] lex_start;
    logic [15:0] lex_len;
    logic        lex_hex;
    logic        lex_single;
    logic [7:0]  lex_depth;

    t_result     step_tok [2];
    int          step_cnt;
    t_result     tokens_due [$];

    int          errors      = 0;
    int          cycles      = 0;
    int          bytes_sent  = 0;
    logic        idle_active = 1'b1;
    logic        calm        = 1'b0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return c >= "A" && c <= "F";
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_FF || c == CH_VT
            || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        case (c)
            "=":     return K_EQUAL;
            "#":     return K_HASH;
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_STAR;
            "/":     return K_SLASH;
            ",":     return K_COMMA;
            ".":     return K_PERIOD;
            ";":     return K_SEMICOLON;
            ")":     return K_RPAREN;
            default: return K_UNKNOWN;
        endcase
    endfunction

    function automatic logic [4:0] pair_kind(input t_pair p, input logic with_eq);
        case (p)
            PAIR_COLON: return with_eq ? K_ASSIGN : K_COLON;
            PAIR_LESS:  return with_eq ? K_LESS_EQ : K_LESS;
            default:    return with_eq ? K_GREATER_EQ : K_GREATER;
        endcase
    endfunction

    function automatic void reset_scanner();
        lex_mode   = SM_IDLE;
        lex_pair   = PAIR_NONE;
        lex_pos    = '0;
        lex_start  = '0;
        lex_len    = '0;
        lex_hex    = 1'b0;
        lex_single = 1'b0;
        lex_depth  = '0;
    endfunction

    function automatic void note(input logic [4:0] kind, input logic [1:0] err,
                                 input logic [15:0] start, input logic [15:0] len);
        if (step_cnt < 2) begin
            step_tok[step_cnt] = '{kind, err, start, len, 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void start_token(input t_lex_mode m);
        lex_mode  = m;
        lex_start = lex_pos;
        lex_len   = 16'd1;
    endfunction

    function automatic void grow();
        if (lex_len != LEN_MAX) lex_len++;
    endfunction

    function automatic t_lex_mode comment_next(input logic [7:0] c);
        return (c == "(") ? SM_COMMENT_LP : (c == "*") ? SM_COMMENT_ST : SM_COMMENT;
    endfunction

    function automatic void scan_idle(input logic [7:0] c);
        if (is_space(c)) begin
            return;
        end
        if (is_head(c)) begin
            start_token(SM_IDENT);
        end else if (is_digit(c)) begin
            start_token(SM_NUMBER);
            lex_hex = 1'b0;
        end else if (c == "\"" || c == "'") begin
            start_token(SM_STRING);
            lex_single = (c == "'");
        end else if (c == "(") begin
            start_token(SM_LPAREN);
        end else if (c == ":" || c == "<" || c == ">") begin
            start_token(SM_PAIR);
            lex_pair = (c == ":") ? PAIR_COLON : (c == "<") ? PAIR_LESS : PAIR_GREATER;
        end else begin
            note(op_kind(c), ERR_NONE, lex_pos, 16'd1);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic eot);
        logic       again;
        logic [1:0] err;
        again    = 1'b0;
        err      = ERR_NONE;
        step_cnt = 0;
        if (eot) begin
            case (lex_mode)
                SM_IDENT:  note(K_IDENT, ERR_NONE, lex_start, lex_len);
                SM_NUMBER: note(K_INTEGER, lex_hex ? ERR_HEX : ERR_NONE, lex_start, lex_len);
                SM_STRING: note(K_STRING, ERR_STRING, lex_start, lex_len);
                SM_LPAREN: note(K_LPAREN, ERR_NONE, lex_start, 16'd1);
                SM_PAIR:   note(pair_kind(lex_pair, 1'b0), ERR_NONE, lex_start, 16'd1);
                SM_COMMENT, SM_COMMENT_LP, SM_COMMENT_ST: begin
                    if (lex_depth != 0) err = ERR_COMMENT;
                end
                default: ;
            endcase
            note(K_EOF, err, lex_pos, 16'd0);
            reset_scanner();
        end else begin
            case (lex_mode)
                SM_IDENT: begin
                    if (is_head(c) || is_digit(c)) begin
                        grow();
                    end else begin
                        note(K_IDENT, ERR_NONE, lex_start, lex_len);
                        again = 1'b1;
                    end
                end
                SM_NUMBER: begin
                    if (is_digit(c) || is_hex_letter(c)) begin
                        if (!is_digit(c)) lex_hex = 1'b1;
                        grow();
                    end else if (c == "H") begin
                        grow();
                        note(K_INTEGER, ERR_NONE, lex_start, lex_len);
                        lex_mode = SM_IDLE;
                    end else begin
                        note(K_INTEGER, lex_hex ? ERR_HEX : ERR_NONE, lex_start, lex_len);
                        again = 1'b1;
                    end
                end
                SM_STRING: begin
                    grow();
                    if (c == (lex_single ? "'" : "\"")) begin
                        note(K_STRING, ERR_NONE, lex_start, lex_len);
                        lex_mode = SM_IDLE;
                    end else if (c == CH_CR || c == CH_LF) begin
                        note(K_STRING, ERR_STRING, lex_start, lex_len);
                        lex_mode = SM_IDLE;
                    end
                end
                SM_LPAREN: begin
                    if (c == "*") begin
                        lex_mode  = SM_COMMENT;
                        lex_depth = 8'd1;
                    end else begin
                        note(K_LPAREN, ERR_NONE, lex_start, 16'd1);
                        again = 1'b1;
                    end
                end
                SM_PAIR: begin
                    if (c == "=") begin
                        note(pair_kind(lex_pair, 1'b1), ERR_NONE, lex_start, 16'd2);
                        lex_mode = SM_IDLE;
                    end else begin
                        note(pair_kind(lex_pair, 1'b0), ERR_NONE, lex_start, 16'd1);
                        again = 1'b1;
                    end
                    lex_pair = PAIR_NONE;
                end
                SM_COMMENT_LP: begin
                    if (c == "*") begin
                        if (lex_depth < MAX_DEPTH) lex_depth++;
                        lex_mode = SM_COMMENT;
                    end else begin
                        lex_mode = (c == "(") ? SM_COMMENT_LP : SM_COMMENT;
                    end
                end
                SM_COMMENT_ST: begin
                    if (c == ")") begin
                        if (lex_depth != 0) lex_depth--;
                        lex_mode = (lex_depth == 0) ? SM_IDLE : SM_COMMENT;
                    end else begin
                        lex_mode = comment_next(c);
                    end
                end
                SM_COMMENT: lex_mode = comment_next(c);
                default:    again = 1'b1;
            endcase
            if (again) begin
                lex_mode = SM_IDLE;
                scan_idle(c);
            end
            lex_pos = lex_pos + 16'd1;
        end
        if (step_cnt > 0) step_tok[step_cnt - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] string_filler(input logic [7:0] q);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == q || b == CH_CR || b == CH_LF) b = ".";
        return b;
    endfunction

    task automatic feed(input logic [7:0] b, input logic eot = 1'b0,
                        input logic [1:0] n_typed = 2'd0,
                        input t_result r0 = NO_TOK, input t_result r1 = NO_TOK);
        if (!calm && idle_active && $urandom_range(0, 7) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        do @(posedge i_clk); while (text_ch.ready !== 1'b1);
        bytes_sent++;
        if (bytes_sent % 50 == 0) idle_active = ($urandom_range(0, 3) != 0);
        scan_byte(b, eot);
        if (n_typed == 2'd0) begin
            for (int i = 0; i < step_cnt; i++) tokens_due.push_back(step_tok[i]);
        end else begin
            tokens_due.push_back(r0);
            if (n_typed == 2'd2) tokens_due.push_back(r1);
        end
    endtask

    task automatic send_lexeme();
        logic [7:0] q;
        int         d;
        int         n;
        case ($urandom_range(0, 21))
            0, 1, 2, 3: begin
                feed(pick(HEAD_CHARS));
                repeat ($urandom_range(0, 7)) feed(pick(WORD_CHARS));
            end
            4: repeat ($urandom_range(1, 5)) feed(pick(DIGITS));
            5, 6: begin
                feed(pick(DIGITS));
                repeat ($urandom_range(0, 4)) feed(pick(HEX_DIGITS));
                if ($urandom_range(0, 1) == 0) feed("H");
            end
            7, 8: begin
                q = ($urandom_range(0, 1) == 0) ? "'" : "\"";
                feed(q);
                repeat ($urandom_range(0, 8)) feed(string_filler(q));
                case ($urandom_range(0, 5))
                    0:       feed(CH_LF);
                    1:       feed(CH_CR);
                    2:       feed(8'($urandom_range(0, 255)), 1'b1);
                    default: feed(q);
                endcase
            end
            9: begin
                feed("(");
                feed("*");
                d = 1;
                n = $urandom_range(0, 10);
                while (d > 0) begin
                    if (n == 0) begin
                        feed("*");
                        feed(")");
                        d--;
                    end else begin
                        n--;
                        case ($urandom_range(0, 4))
                            0: begin
                                if (d < 3) begin
                                    feed("(");
                                    feed("*");
                                    d++;
                                end
                            end
                            1: begin
                                feed("*");
                                feed(")");
                                d--;
                            end
                            2:       feed(pick(NEST_CHARS));
                            default: feed(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
            end
            10, 11: begin
                feed(pick(":<>"));
                if ($urandom_range(0, 1) == 0) feed("=");
            end
            12, 13, 14: feed(pick(OP_CHARS));
            15, 16: begin
                case ($urandom_range(0, 5))
                    0:       feed(CH_TAB);
                    1:       feed(CH_LF);
                    2:       feed(CH_CR);
                    3:       feed(CH_VT);
                    4:       feed(CH_FF);
                    default: feed(" ");
                endcase
            end
            17: begin
                case ($urandom_range(0, 2))
                    0:       feed(8'($urandom_range(128, 255)));
                    1:       feed(8'h00);
                    default: feed(pick(ODD_CHARS));
                endcase
            end
            18: repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 255)));
            default: feed(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    initial begin : stimulus
        int mark;
        i_rst_n             <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.end_of_text <= 1'b0;
        reset_scanner();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            feed(DIR_TABLE[i].b, DIR_TABLE[i].eot, DIR_TABLE[i].n_typed,
                 DIR_TABLE[i].r0, DIR_TABLE[i].r1);
        end

        mark = bytes_sent;
        while (bytes_sent < mark + 300) send_lexeme();
        feed(8'h00, 1'b1);

        // nest past the depth ceiling, then unwind exactly the ceiling
        repeat (MAX_DEPTH + 5) begin
            feed("(");
            feed("*");
        end
        repeat (MAX_DEPTH) begin
            feed("*");
            feed(")");
        end
        feed(")");
        feed(" ");
        feed(8'h00, 1'b1);

        mark = bytes_sent;
        while (bytes_sent < mark + 150) send_lexeme();
        calm = 1'b1;
        mark = bytes_sent;
        while (bytes_sent < mark + 200) send_lexeme();
        feed(8'h00, 1'b1);
        text_ch.valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        stall = 0;
        token_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall != 0) begin
                stall--;
                token_ch.ready <= 1'b0;
            end else if (!calm && idle_active && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 14);
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: token with none expected, expected none, actual kind %0d start %0d",
                         $time, token_ch.token_kind, token_ch.token_start);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", want.kind, token_ch.token_kind);
                check_field("error_code", want.err, token_ch.error_code);
                check_field("token_start", want.start, token_ch.token_start);
                check_field("token_length", want.len, token_ch.token_length);
                check_field("last_in_run", want.last, token_ch.last_in_run);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
